// ----- rtl/tbt_pkg.sv -----
// ----------------------------------------------------------------------------
// tbt_pkg
// Shared codes, field widths and the command record passed from the request
// decoder through the command queue to the bucket table.
// ----------------------------------------------------------------------------
package tbt_pkg;

  localparam int REQ_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int CNT_W    = 16;
  localparam int STATUS_W = 3;
  localparam int GIVEN_W  = 6;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam req_t REQ_TICK      = 3'd0;
  localparam req_t REQ_OPEN      = 3'd1;
  localparam req_t REQ_FETCH     = 3'd2;
  localparam req_t REQ_GIVE      = 3'd3;
  localparam req_t REQ_CLOSE     = 3'd4;
  localparam req_t REQ_CLOSE_ALL = 3'd5;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_INVALID   = 3'd1;
  localparam status_t ST_NO_SLOT   = 3'd2;
  localparam status_t ST_NO_TOKENS = 3'd3;
  localparam status_t ST_NOT_OPEN  = 3'd4;

  typedef struct packed {
    req_t              req;
    logic              bad_arg;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  rate;
    logic [CNT_W-1:0]  depth_limit;
  } tbt_cmd_t;

endpackage

// ----- rtl/tbt_front.sv -----
// ----------------------------------------------------------------------------
// tbt_front
// Request decoder: checks slot range, zero counts and unknown request types
// and packs the request into a command record for the queue.
// ----------------------------------------------------------------------------
module tbt_front import tbt_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  req_t              req_type,
  input  logic [SLOT_W-1:0] slot,
  input  logic [CNT_W-1:0]  count,
  input  logic [CNT_W-1:0]  rate,
  input  logic [CNT_W-1:0]  depth_limit,
  output tbt_cmd_t          cmd
);

  logic slot_bad;
  logic bad;

  assign slot_bad = (32'(slot) >= 32'(NUM_SLOTS));

  always_comb begin
    case (req_type)
      REQ_TICK, REQ_OPEN, REQ_CLOSE_ALL: bad = 1'b0;
      REQ_FETCH, REQ_GIVE:               bad = slot_bad || (count == '0);
      REQ_CLOSE:                         bad = slot_bad;
      default:                           bad = 1'b1;
    endcase
  end

  always_comb begin
    cmd.req         = req_type;
    cmd.bad_arg     = bad;
    cmd.slot        = slot;
    cmd.count       = count;
    cmd.rate        = rate;
    cmd.depth_limit = depth_limit;
  end

endmodule

// ----- rtl/tbt_queue.sv -----
// ----------------------------------------------------------------------------
// tbt_queue
// Short command queue between the decoder and the bucket table.
// ----------------------------------------------------------------------------
module tbt_queue import tbt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  tbt_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output tbt_cmd_t pop_data
);

  tbt_cmd_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push_fire;
  logic                pop_fire;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_fire) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= QDEPTH)
    else $error("command queue count out of range");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QCNT_W'(QDEPTH)) && !pop_fire |=> (cnt_r == QCNT_W'(QDEPTH)))
    else $error("full queue lost an entry without a pop");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop_fire && !push_fire |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count did not drop after a pop");

endmodule

// ----- rtl/tbt_back.sv -----
// ----------------------------------------------------------------------------
// tbt_back
// Bucket table: per-slot token cells updated in parallel, a priority encoder
// for open, and the result register.
// ----------------------------------------------------------------------------
module tbt_back import tbt_pkg::*; #(
  parameter int NUM_SLOTS   = 8,
  parameter int TOKEN_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  tbt_cmd_t            cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output status_t             out_status,
  output logic [GIVEN_W-1:0]  out_slot_given,
  output logic [CNT_W-1:0]    out_amount
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW    = (TOKEN_WIDTH > CNT_W) ? TOKEN_WIDTH : CNT_W;
  localparam int SUM_W = CW + 1;
  localparam int TW    = TOKEN_WIDTH;

  logic [NUM_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [TW-1:0]        tokens_r   [NUM_SLOTS];
  logic [TW-1:0]        tokens_nxt [NUM_SLOTS];
  logic [TW-1:0]        rate_r     [NUM_SLOTS];
  logic [TW-1:0]        cap_r      [NUM_SLOTS];
  logic [TW:0]          tick_sum   [NUM_SLOTS];
  logic [TW-1:0]        tick_val   [NUM_SLOTS];

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, status_nxt;
  logic [GIVEN_W-1:0]   out_given_r, given_nxt;
  logic [CNT_W-1:0]     out_amount_r, amount_nxt;

  logic                 fire;
  logic                 cfg_wr;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     idx;
  logic [TW-1:0]        have;
  logic [TW-1:0]        cap;
  logic [CW-1:0]        f_take;
  logic [SUM_W-1:0]     g_sum;
  logic [TW-1:0]        g_after;
  logic [TW-1:0]        g_added;

  assign cmd_ready = !out_valid_r || out_ready;
  assign fire      = cmd_valid && cmd_ready;

  assign idx  = IDX_W'(cmd.slot);
  assign have = tokens_r[idx];
  assign cap  = cap_r[idx];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // per-slot refill
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tick_sum[i] = {1'b0, tokens_r[i]} + {1'b0, rate_r[i]};
      tick_val[i] = (tick_sum[i] >= {1'b0, cap_r[i]}) ? cap_r[i] : tick_sum[i][TW-1:0];
    end
  end

  always_comb begin
    f_take  = (CW'(have) < CW'(cmd.count)) ? CW'(have) : CW'(cmd.count);
    g_sum   = SUM_W'(have) + SUM_W'(cmd.count);
    g_after = (g_sum >= SUM_W'(cap)) ? cap : TW'(g_sum);
    g_added = (g_after >= have) ? (g_after - have) : '0;
  end

  always_comb begin
    in_use_nxt = in_use_r;
    tokens_nxt = tokens_r;
    status_nxt = ST_OK;
    given_nxt  = '0;
    amount_nxt = '0;
    cfg_wr     = 1'b0;
    if (cmd.bad_arg) begin
      status_nxt = ST_INVALID;
    end else begin
      case (cmd.req)
        REQ_TICK: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (in_use_r[i]) begin
              tokens_nxt[i] = tick_val[i];
            end
          end
        end
        REQ_OPEN: begin
          if (free_found) begin
            in_use_nxt[free_idx] = 1'b1;
            tokens_nxt[free_idx] = '0;
            given_nxt            = GIVEN_W'(free_idx);
            cfg_wr               = 1'b1;
          end else begin
            status_nxt = ST_NO_SLOT;
          end
        end
        REQ_FETCH: begin
          if (!in_use_r[idx]) begin
            status_nxt = ST_NOT_OPEN;
          end else if (have == '0) begin
            status_nxt = ST_NO_TOKENS;
          end else begin
            tokens_nxt[idx] = have - TW'(f_take);
            amount_nxt      = CNT_W'(f_take);
          end
        end
        REQ_GIVE: begin
          if (!in_use_r[idx]) begin
            status_nxt = ST_NOT_OPEN;
          end else begin
            tokens_nxt[idx] = g_after;
            amount_nxt      = CNT_W'(g_added);
          end
        end
        REQ_CLOSE: begin
          if (!in_use_r[idx]) begin
            status_nxt = ST_NOT_OPEN;
          end else begin
            in_use_nxt[idx] = 1'b0;
            tokens_nxt[idx] = '0;
          end
        end
        REQ_CLOSE_ALL: begin
          in_use_nxt = '0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            tokens_nxt[i] = '0;
          end
        end
        default: begin
          status_nxt = ST_INVALID;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= '0;
      tokens_r    <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        in_use_r <= in_use_nxt;
        tokens_r <= tokens_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status_nxt;
      out_given_r  <= given_nxt;
      out_amount_r <= amount_nxt;
    end
    if (fire && cfg_wr) begin
      rate_r[free_idx] <= TW'(cmd.rate);
      cap_r[free_idx]  <= TW'(cmd.depth_limit);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_given = out_given_r;
  assign out_amount     = out_amount_r;

  a_close_all: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !cmd.bad_arg && (cmd.req == REQ_CLOSE_ALL) |=> (in_use_r == '0))
    else $error("close all left a slot open");

  a_open_full: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !cmd.bad_arg && (cmd.req == REQ_OPEN) && (&in_use_r)
    |=> (out_status_r == ST_NO_SLOT))
    else $error("open on a full table did not report no free slot");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("served command produced no result");

endmodule

// ----- rtl/token_bucket_table.sv -----
// ----------------------------------------------------------------------------
// token_bucket_table
// Table of NUM_SLOTS token buckets serving tick, open, fetch, give back,
// close and close all requests, one result beat per request beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request beat (req_type, slot, count, rate, depth_limit), valid/ready
//   out_* : result beat (status, slot_given, amount), valid/ready
//   A request beat lands in a two-entry command queue; the bucket table takes
//   it from the queue when its result register is empty or being taken and
//   registers the result, so each result passes through a queue entry and
//   then the result register before it is offered.
//   Throughput is one request per cycle while the receiver takes results:
//   every request, tick and close all included, updates the per-slot cells in
//   parallel, and open picks the lowest free slot through a priority encoder in the same cycle.
//   When the receiver stalls, the result register holds, the table stops
//   taking commands and the queue absorbs up to two more requests before
//   in_ready drops.
//   Reset (rst_n low, synchronous) frees every slot, zeroes every token
//   count and empties the queue and the result register; refill rates and
//   caps are written only by open.
// ----------------------------------------------------------------------------
module token_bucket_table import tbt_pkg::*; #(
  parameter int NUM_SLOTS   = 8,
  parameter int TOKEN_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               in_req_type,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [CNT_W-1:0]   in_count,
  input  logic [CNT_W-1:0]   in_rate,
  input  logic [CNT_W-1:0]   in_depth_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output status_t            out_status,
  output logic [GIVEN_W-1:0] out_slot_given,
  output logic [CNT_W-1:0]   out_amount
);

  tbt_cmd_t front_cmd;
  tbt_cmd_t q_cmd;
  logic     q_valid;
  logic     q_ready;

  tbt_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .req_type    (in_req_type),
    .slot        (in_slot),
    .count       (in_count),
    .rate        (in_rate),
    .depth_limit (in_depth_limit),
    .cmd         (front_cmd)
  );

  tbt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  tbt_back #(
    .NUM_SLOTS   (NUM_SLOTS),
    .TOKEN_WIDTH (TOKEN_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (q_valid),
    .cmd_ready      (q_ready),
    .cmd            (q_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_given (out_slot_given),
    .out_amount     (out_amount)
  );

endmodule

// ----- test/token_bucket_table_checker.sv -----
// ----------------------------------------------------------------------------
// token_bucket_table_checker
// Watches the request and result channels of the bucket table, keeps its own
// copy of every bucket, works out the result of each accepted request beat
// and compares each accepted result beat, field by field, in order.
// ----------------------------------------------------------------------------
module token_bucket_table_checker import tbt_pkg::*; #(
  parameter int NUM_SLOTS   = 8,
  parameter int TOKEN_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  req_t               in_req_type,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [CNT_W-1:0]   in_count,
  input  logic [CNT_W-1:0]   in_rate,
  input  logic [CNT_W-1:0]   in_depth_limit,
  input  logic               out_valid,
  input  logic               out_ready,
  input  status_t            out_status,
  input  logic [GIVEN_W-1:0] out_slot_given,
  input  logic [CNT_W-1:0]   out_amount,
  output int                 fail_count,
  output int                 outstanding,
  output int                 beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef logic [TOKEN_WIDTH-1:0] token_t;

  typedef struct packed {
    status_t            status;
    logic [GIVEN_W-1:0] given;
    logic [CNT_W-1:0]   amount;
  } bucket_result_t;

  logic           slot_open [NUM_SLOTS];
  token_t         tokens    [NUM_SLOTS];
  token_t         refill    [NUM_SLOTS];
  token_t         cap       [NUM_SLOTS];
  bucket_result_t pending_results[$];
  bucket_result_t wanted;
  int             mismatches;
  int             compared;

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    beats_checked = 0;
    mismatches    = 0;
    compared      = 0;
  end

  function automatic token_t add_with_cap(token_t have, token_t add, token_t limit);
    logic [TOKEN_WIDTH:0] sum;
    sum = {1'b0, have} + {1'b0, add};
    return (sum >= {1'b0, limit}) ? limit : sum[TOKEN_WIDTH-1:0];
  endfunction

  function automatic bucket_result_t serve_request(req_t req, logic [SLOT_W-1:0] slot,
                                                   logic [CNT_W-1:0] count,
                                                   logic [CNT_W-1:0] rate,
                                                   logic [CNT_W-1:0] depth);
    bucket_result_t   res;
    token_t           held;
    token_t           after;
    int               i;
    logic [IDX_W-1:0] idx;
    idx        = IDX_W'(slot);
    res.status = ST_OK;
    res.given  = '0;
    res.amount = '0;
    case (req)
      REQ_TICK: begin
        for (i = 0; i < NUM_SLOTS; i++)
          if (slot_open[i]) tokens[i] = add_with_cap(tokens[i], refill[i], cap[i]);
      end
      REQ_OPEN: begin
        res.status = ST_NO_SLOT;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (!slot_open[i] && res.status == ST_NO_SLOT) begin
            slot_open[i] = 1'b1;
            refill[i]    = TOKEN_WIDTH'(rate);
            cap[i]       = TOKEN_WIDTH'(depth);
            tokens[i]    = '0;
            res.given    = GIVEN_W'(i);
            res.status   = ST_OK;
          end
        end
      end
      REQ_FETCH, REQ_GIVE: begin
        if (slot >= NUM_SLOTS || count == 0) begin
          res.status = ST_INVALID;
        end else if (!slot_open[idx]) begin
          res.status = ST_NOT_OPEN;
        end else if (req == REQ_FETCH) begin
          held = tokens[idx];
          if (held == 0) begin
            res.status = ST_NO_TOKENS;
          end else begin
            res.amount  = (held < count) ? CNT_W'(held) : count;
            tokens[idx] = held - TOKEN_WIDTH'(res.amount);
          end
        end else begin
          held        = tokens[idx];
          after       = add_with_cap(held, TOKEN_WIDTH'(count), cap[idx]);
          tokens[idx] = after;
          res.amount  = (after >= held) ? CNT_W'(after - held) : '0;
        end
      end
      REQ_CLOSE: begin
        if (slot >= NUM_SLOTS) begin
          res.status = ST_INVALID;
        end else if (!slot_open[idx]) begin
          res.status = ST_NOT_OPEN;
        end else begin
          slot_open[idx] = 1'b0;
          tokens[idx]    = '0;
        end
      end
      REQ_CLOSE_ALL: begin
        for (i = 0; i < NUM_SLOTS; i++) begin
          slot_open[i] = 1'b0;
          tokens[i]    = '0;
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_results.delete();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_open[i] = 1'b0;
        tokens[i]    = '0;
        refill[i]    = '0;
        cap[i]       = '0;
      end
    end else begin
      if (in_valid && in_ready)
        pending_results.push_back(serve_request(in_req_type, in_slot, in_count,
                                                in_rate, in_depth_limit));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result beat with nothing expected, got status %0d slot %0d amount %0d",
                   $time, out_status, out_slot_given, out_amount);
        end else begin
          wanted = pending_results.pop_front();
          compared++;
          if (out_status !== wanted.status) begin
            mismatches++;
            $display("%0t ns: status expected %0d, got %0d", $time, wanted.status, out_status);
          end
          if (out_slot_given !== wanted.given) begin
            mismatches++;
            $display("%0t ns: slot_given expected %0d, got %0d", $time, wanted.given,
                     out_slot_given);
          end
          if (out_amount !== wanted.amount) begin
            mismatches++;
            $display("%0t ns: amount expected %0d, got %0d", $time, wanted.amount, out_amount);
          end
        end
      end
    end
    outstanding   <= pending_results.size();
    fail_count    <= mismatches;
    beats_checked <= compared;
  end

endmodule

// ----- test/token_bucket_table_tb.sv -----
// ----------------------------------------------------------------------------
// token_bucket_table_tb
// Drives request beats into the bucket table: a directed opening that walks
// every request kind and error case, then a long random mix of opens, ticks,
// fetches, give-backs and closes with random gaps and output stalls, one long
// output hold-off and one drain pause. The checker beside the block judges it.
// ----------------------------------------------------------------------------
module token_bucket_table_tb import tbt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   RANDOM_ITEMS = 750;
  localparam int   QUIET_ITEMS  = 100;
  localparam int   HOLD_AT      = 200;
  localparam int   PAUSE_AT     = 450;
  localparam int   LONG_STALL   = 60;
  localparam int   TAIL_CYCLES  = 8;
  localparam int   CYCLE_LIMIT  = 300000;
  localparam req_t REQ_BAD_LO   = 3'd6;
  localparam req_t REQ_BAD_HI   = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  req_t               in_req_type;
  logic [SLOT_W-1:0]  in_slot;
  logic [CNT_W-1:0]   in_count;
  logic [CNT_W-1:0]   in_rate;
  logic [CNT_W-1:0]   in_depth_limit;
  logic               out_valid;
  logic               out_ready;
  status_t            out_status;
  logic [GIVEN_W-1:0] out_slot_given;
  logic [CNT_W-1:0]   out_amount;

  int fail_count;
  int outstanding;
  int beats_checked;
  int beats_sent  = 0;
  int cycle_count = 0;
  bit quiet       = 1'b0;
  bit stall_request = 1'b0;
  int long_stalls = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  token_bucket_table u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_slot        (in_slot),
    .in_count       (in_count),
    .in_rate        (in_rate),
    .in_depth_limit (in_depth_limit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_given (out_slot_given),
    .out_amount     (out_amount)
  );

  token_bucket_table_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_slot        (in_slot),
    .in_count       (in_count),
    .in_rate        (in_rate),
    .in_depth_limit (in_depth_limit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_given (out_slot_given),
    .out_amount     (out_amount),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .beats_checked  (beats_checked)
  );

  task automatic send_request(req_t req, logic [SLOT_W-1:0] slot, logic [CNT_W-1:0] count,
                              logic [CNT_W-1:0] rate, logic [CNT_W-1:0] depth);
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_slot        <= slot;
    in_count       <= count;
    in_rate        <= rate;
    in_depth_limit <= depth;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2, 3:    return CNT_W'($urandom_range(0, 65535));
      default: return CNT_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return CNT_W'($urandom_range(0, 65535));
      default: return CNT_W'($urandom_range(1, 60));
    endcase
  endfunction

  task automatic send_random_request();
    int                sel;
    req_t              req;
    logic [SLOT_W-1:0] slot;
    sel = $urandom_range(0, 99);
    if (sel < 18)      req = REQ_TICK;
    else if (sel < 36) req = REQ_OPEN;
    else if (sel < 62) req = REQ_FETCH;
    else if (sel < 84) req = REQ_GIVE;
    else if (sel < 93) req = REQ_CLOSE;
    else if (sel < 95) req = REQ_CLOSE_ALL;
    else               req = ($urandom_range(0, 1) == 0) ? REQ_BAD_LO : REQ_BAD_HI;
    if ($urandom_range(0, 9) == 0) slot = SLOT_W'($urandom_range(8, 15));
    else                           slot = SLOT_W'($urandom_range(0, 7));
    send_request(req, slot, pick_count(), pick_level(), pick_level());
  endtask

  // output side: random stall bursts plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_request) begin
        out_ready <= 1'b0;
        for (int n = 0; n < LONG_STALL; n++) @(posedge clk);
        long_stalls++;
        stall_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("token_bucket_table: mismatch");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_req_type    <= REQ_TICK;
    in_slot        <= '0;
    in_count       <= '0;
    in_rate        <= '0;
    in_depth_limit <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // errors on an empty table
    send_request(REQ_FETCH, 0, 1, 0, 0);
    send_request(REQ_CLOSE, 3, 0, 0, 0);
    send_request(REQ_FETCH, 8, 5, 0, 0);
    send_request(REQ_GIVE, 15, 0, 0, 0);
    send_request(REQ_FETCH, 0, 0, 0, 0);
    send_request(REQ_BAD_LO, 0, 1, 1, 1);
    send_request(REQ_BAD_HI, 15, '1, '1, '1);
    // opens, empty fetch, refill and clamping
    send_request(REQ_OPEN, 0, 0, '1, '1);
    send_request(REQ_OPEN, 0, 0, 1, 3);
    send_request(REQ_OPEN, 0, 0, 0, 0);
    send_request(REQ_FETCH, 0, 5, 0, 0);
    send_request(REQ_TICK, 0, 0, 0, 0);
    send_request(REQ_TICK, 0, 0, 0, 0);
    send_request(REQ_FETCH, 0, '1, 0, 0);
    send_request(REQ_GIVE, 1, '1, 0, 0);
    send_request(REQ_GIVE, 1, 1, 0, 0);
    send_request(REQ_FETCH, 1, 1, 0, 0);
    send_request(REQ_FETCH, 2, 1, 0, 0);
    // fill the table, then overflow it
    for (int i = 0; i < 5; i++) send_request(REQ_OPEN, 0, 0, CNT_W'(i + 1), CNT_W'(65535 - i));
    send_request(REQ_OPEN, 0, 0, 7, 7);
    send_request(REQ_CLOSE, 7, 0, 0, 0);
    send_request(REQ_CLOSE, 7, 0, 0, 0);
    send_request(REQ_GIVE, 0, '1, 0, 0);
    send_request(REQ_CLOSE_ALL, 0, 0, 0, 0);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      if (n == HOLD_AT) stall_request = 1'b1;
      if (n == PAUSE_AT) wait_drained();
      if (!quiet && !(n >= HOLD_AT && n < HOLD_AT + 30) && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      send_random_request();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d request beats, compared %0d result beats in %0d cycles",
             beats_sent, beats_checked, cycle_count);
    $display("covered error cases, full table, bucket clamping, %0d long output hold-off",
             long_stalls);
    if (fail_count == 0) begin
      $display("token_bucket_table: match");
    end else begin
      $display("token_bucket_table: mismatch");
    end
    $finish;
  end

endmodule
